// ----- hw/rtl/command_reply_frame_checker_defines.svh -----
// Assertion helpers shared by the checker RTL.
// Each macro expects clk and rst_n to be visible in the enclosing module.
`ifndef COMMAND_REPLY_FRAME_CHECKER_DEFINES_SVH
`define COMMAND_REPLY_FRAME_CHECKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/crfc_pkg.sv -----
package crfc_pkg;

    localparam int TIMEOUT_W = 10;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_TIMEOUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 2'd3;

    // frame phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HDR_TIMEOUT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LEN_TIMEOUT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BODY_TIMEOUT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ID_MISMATCH  = 3'd6;

    localparam logic [BYTE_W-1:0] HEADER_BYTE      = 8'h5A;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd4;

    localparam logic [TIMEOUT_W-1:0] HEADER_TIMEOUT_RST = 10'd250;
    localparam logic [TIMEOUT_W-1:0] LENGTH_TIMEOUT_RST = 10'd50;
    localparam logic [TIMEOUT_W-1:0] BODY_TIMEOUT_RST   = 10'd100;
    localparam logic [BYTE_W-1:0]    MAX_LENGTH_RST     = 8'd32;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] expected_id;
    } crfc_item_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] header_timeout_ms;
        logic [TIMEOUT_W-1:0] length_timeout_ms;
        logic [TIMEOUT_W-1:0] body_timeout_ms;
        logic [BYTE_W-1:0]    max_frame_length;
    } crfc_cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   reply_id;
        logic [BYTE_W-1:0]   reply_length;
    } crfc_result_t;

endpackage

// ----- hw/rtl/command_reply_frame_checker.sv -----
// Checks a sensor reply frame (0x5A header, length, id, payload, 8-bit sum)
// against the command id given with the start transaction, timing each
// phase in millisecond ticks. Takes one transaction per clock while results
// drain; result_valid rises once the transaction causing it has passed from
// the input register through the combinational frame update into the result
// register. While a result is held by result_ready low, one more transaction
// is taken into the input register and further input waits. Bytes and
// ticks while idle, and unknown operations, produce no result. Timeout and
// length registers should be written only while no check is in progress.
`include "command_reply_frame_checker_defines.svh"

module command_reply_frame_checker
    import crfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic [BYTE_W-1:0]     rx_byte,
    input  logic [BYTE_W-1:0]     expected_id,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [BYTE_W-1:0]     reply_id,
    output logic [BYTE_W-1:0]     reply_length
);

    crfc_cfg_t    cfg;
    crfc_item_t   item_reg;
    logic         item_valid_reg;
    logic         fire;
    logic         res_valid;
    crfc_result_t res;
    crfc_result_t result_reg;
    logic         result_valid_reg;

    // stage advances whenever it holds a transaction and the result register is free or draining
    assign fire       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.operation   <= operation;
            item_reg.rx_byte     <= rx_byte;
            item_reg.expected_id <= expected_id;
        end
    end

    crfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crfc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (fire && res_valid)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
            result_reg <= res;
    end

    assign result_valid = result_valid_reg;
    assign status       = result_reg.status;
    assign reply_id     = result_reg.reply_id;
    assign reply_length = result_reg.reply_length;

    `CRFC_ASSERT_NOW(a_ok_length, result_valid_reg && result_reg.status == ST_OK, result_reg.reply_length >= MIN_FRAME_LENGTH, "ok reply shorter than minimum")

endmodule

// ----- hw/rtl/crfc_cfg.sv -----
module crfc_cfg
    import crfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output crfc_cfg_t             cfg
);

    crfc_cfg_t cfg_reg;
    crfc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_TIMEOUT: cfg_next.header_timeout_ms = cfg_data;
                CFG_LENGTH_TIMEOUT: cfg_next.length_timeout_ms = cfg_data;
                CFG_BODY_TIMEOUT:   cfg_next.body_timeout_ms   = cfg_data;
                CFG_MAX_LENGTH:     cfg_next.max_frame_length  = cfg_data[BYTE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_timeout_ms <= HEADER_TIMEOUT_RST;
            cfg_reg.length_timeout_ms <= LENGTH_TIMEOUT_RST;
            cfg_reg.body_timeout_ms   <= BODY_TIMEOUT_RST;
            cfg_reg.max_frame_length  <= MAX_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/crfc_core.sv -----
`include "command_reply_frame_checker_defines.svh"

module crfc_core
    import crfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  crfc_item_t   item,
    input  crfc_cfg_t    cfg,
    output logic         res_valid,
    output crfc_result_t res
);

    logic [1:0]           phase_reg,        phase_next;
    logic [TIMEOUT_W-1:0] elapsed_reg,      elapsed_next;
    logic [BYTE_W-1:0]    bytes_left_reg,   bytes_left_next;
    logic [BYTE_W-1:0]    sum_reg,          sum_next;
    logic [BYTE_W-1:0]    frame_length_reg, frame_length_next;
    logic [BYTE_W-1:0]    reply_id_reg,     reply_id_next;
    logic [BYTE_W-1:0]    wanted_id_reg,    wanted_id_next;
    logic                 id_seen_reg,      id_seen_next;

    logic [TIMEOUT_W:0]   elapsed_inc;
    logic [BYTE_W-1:0]    body_id;

    assign elapsed_inc = {1'b0, elapsed_reg} + {{TIMEOUT_W{1'b0}}, 1'b1};
    // first body byte is the id
    assign body_id = id_seen_reg ? reply_id_reg : item.rx_byte;

    always_comb
    begin
        phase_next        = phase_reg;
        elapsed_next      = elapsed_reg;
        bytes_left_next   = bytes_left_reg;
        sum_next          = sum_reg;
        frame_length_next = frame_length_reg;
        reply_id_next     = reply_id_reg;
        wanted_id_next    = wanted_id_reg;
        id_seen_next      = id_seen_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (fire)
        begin
            unique case (item.operation)
                OP_START:
                begin
                    phase_next        = PH_HEADER;
                    elapsed_next      = '0;
                    bytes_left_next   = '0;
                    sum_next          = '0;
                    frame_length_next = '0;
                    reply_id_next     = '0;
                    id_seen_next      = 1'b0;
                    wanted_id_next    = item.expected_id;
                end
                OP_BYTE:
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (item.rx_byte == HEADER_BYTE)
                            begin
                                phase_next   = PH_LENGTH;
                                elapsed_next = '0;
                                sum_next     = HEADER_BYTE;
                            end
                        end
                        PH_LENGTH:
                        begin
                            frame_length_next = item.rx_byte;
                            if (item.rx_byte < MIN_FRAME_LENGTH ||
                                item.rx_byte > cfg.max_frame_length)
                            begin
                                res_valid          = 1'b1;
                                res.status         = ST_BAD_LENGTH;
                                res.reply_length   = item.rx_byte;
                                phase_next         = PH_IDLE;
                            end
                            else
                            begin
                                sum_next        = sum_reg + item.rx_byte;
                                bytes_left_next = item.rx_byte - 8'd2;
                                elapsed_next    = '0;
                                id_seen_next    = 1'b0;
                                phase_next      = PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            reply_id_next = body_id;
                            if (bytes_left_reg <= 8'd1)
                            begin
                                res_valid        = 1'b1;
                                res.reply_id     = body_id;
                                res.reply_length = frame_length_reg;
                                phase_next       = PH_IDLE;
                                priority if (sum_reg != item.rx_byte)
                                    res.status = ST_CHECKSUM;
                                else if (body_id != wanted_id_reg)
                                    res.status = ST_ID_MISMATCH;
                                else
                                    res.status = ST_OK;
                            end
                            else
                            begin
                                sum_next        = sum_reg + item.rx_byte;
                                bytes_left_next = bytes_left_reg - 8'd1;
                                id_seen_next    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_HEADER:
                        begin
                            if (elapsed_inc >= {1'b0, cfg.header_timeout_ms})
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_HDR_TIMEOUT;
                                phase_next = PH_IDLE;
                            end
                            else
                                elapsed_next = elapsed_inc[TIMEOUT_W-1:0];
                        end
                        PH_LENGTH:
                        begin
                            if (elapsed_reg >= cfg.length_timeout_ms)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_LEN_TIMEOUT;
                                phase_next = PH_IDLE;
                            end
                            else
                                elapsed_next = elapsed_inc[TIMEOUT_W-1:0];
                        end
                        PH_BODY:
                        begin
                            if (elapsed_reg >= cfg.body_timeout_ms)
                            begin
                                res_valid        = 1'b1;
                                res.status       = ST_BODY_TIMEOUT;
                                res.reply_id     = id_seen_reg ? reply_id_reg : '0;
                                res.reply_length = frame_length_reg;
                                phase_next       = PH_IDLE;
                            end
                            else
                                elapsed_next = elapsed_inc[TIMEOUT_W-1:0];
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            elapsed_reg      <= '0;
            bytes_left_reg   <= '0;
            sum_reg          <= '0;
            frame_length_reg <= '0;
            reply_id_reg     <= '0;
            wanted_id_reg    <= '0;
            id_seen_reg      <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            elapsed_reg      <= elapsed_next;
            bytes_left_reg   <= bytes_left_next;
            sum_reg          <= sum_next;
            frame_length_reg <= frame_length_next;
            reply_id_reg     <= reply_id_next;
            wanted_id_reg    <= wanted_id_next;
            id_seen_reg      <= id_seen_next;
        end
    end

    `CRFC_ASSERT_NOW(a_idle_silent, fire && phase_reg == PH_IDLE && item.operation != OP_START, !res_valid, "result produced while idle")
    `CRFC_ASSERT_NEXT(a_done_idle, res_valid, phase_reg == PH_IDLE, "phase not idle after result")
    `CRFC_ASSERT_NOW(a_body_count, phase_reg == PH_BODY, bytes_left_reg != '0, "body byte count ran out")

endmodule
